[hdl/rtc_pkg.sv]
// Shared types and constants for the day/time counter with alarm.
`timescale 1ns / 1ps

package rtc_pkg;

  localparam int unsigned DAY_BITS = 16;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned IN_USER_W  = 6;
  localparam int unsigned OUT_USER_W = 8;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_e;

  localparam logic [3:0] REG_SEC       = 4'd0;
  localparam logic [3:0] REG_MIN       = 4'd1;
  localparam logic [3:0] REG_HRS       = 4'd2;
  localparam logic [3:0] REG_DAY       = 4'd3;
  localparam logic [3:0] REG_ALM_SEC   = 4'd4;
  localparam logic [3:0] REG_ALM_MIN   = 4'd5;
  localparam logic [3:0] REG_ALM_HOUR  = 4'd6;
  localparam logic [3:0] REG_CTRL      = 4'd7;
  localparam logic [3:0] REG_LD_SEC    = 4'd8;
  localparam logic [3:0] REG_LD_MIN    = 4'd9;
  localparam logic [3:0] REG_LD_HOUR   = 4'd10;
  localparam logic [3:0] REG_LD_DAY    = 4'd11;
  localparam logic [3:0] REG_STATUS    = 4'd12;
  localparam logic [3:0] REG_REVISION  = 4'd13;
  localparam logic [3:0] REG_TIME      = 4'd14;

  localparam logic [31:0] REVISION = 32'h0001_0000;

  // control word bits
  localparam int unsigned CTRL_EN    = 0;
  localparam int unsigned CTRL_IALM  = 5;
  localparam int unsigned CTRL_LOAD  = 6;

  // status bits
  localparam int unsigned ST_ALM = 4;

  localparam logic [7:0] SEC_MAX  = 8'd59;
  localparam logic [7:0] HOUR_MAX = 8'd23;

endpackage

[hdl/rtc_day_time_counter_with_alarm_top.sv]
// Real-time clock: sec/min/hour/day counters, alarm, status and register access.
//
//  channel  dir  tdata            tuser
//  s_axis   in   write_data[31:0] opcode[1:0], reg_index[5:2]
//  m_axis   out  read_data[31:0]  alarm_level[0], irq_pulses[5:1], bus_error[6],
//                                 range_warning[7]
//
//  One beat per cycle while the result is not stalled; result appears in the cycle after the input beat.
//  The single result register sets the latency; input is taken whenever that
//  register is empty or being drained in the same cycle.
//  Reset clears all counters, alarm, load, control and status registers.
//  A stalled result holds; the input stalls only while the result waits.
`timescale 1ns / 1ps

module rtc_day_time_counter_with_alarm_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [rtc_pkg::DATA_W-1:0]       s_axis_tdata_i,  // write_data
  input  logic [rtc_pkg::IN_USER_W-1:0]    s_axis_tuser_i,  // opcode, reg_index
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [rtc_pkg::DATA_W-1:0]       m_axis_tdata_o,  // read_data
  output logic [rtc_pkg::OUT_USER_W-1:0]   m_axis_tuser_o   // alarm_level, irq_pulses,
                                                            // bus_error, range_warning
);

  logic [7:0]                   sec_q, sec_d, min_q, min_d, hour_q, hour_d;
  logic [rtc_pkg::DAY_BITS-1:0] day_q, day_d;
  logic [7:0]                   alm_sec_q, alm_sec_d, alm_min_q, alm_min_d;
  logic [7:0]                   alm_hour_q, alm_hour_d;
  logic [7:0]                   ld_sec_q, ld_sec_d, ld_min_q, ld_min_d;
  logic [7:0]                   ld_hour_q, ld_hour_d;
  logic [15:0]                  ld_day_q, ld_day_d;
  logic [31:0]                  ctrl_q, ctrl_d;
  logic [4:0]                   status_q, status_d;

  logic                         m_valid_q, m_valid_d;
  logic [31:0]                  m_data_q;
  logic [7:0]                   m_user_q;

  logic                         in_beat;
  rtc_pkg::op_e                 op;
  logic [3:0]                   idx;
  logic [31:0]                  wd;
  logic [31:0]                  rdata;
  logic                         berr, warn, alarm_chk, pulse_on, alarm_level;
  logic [3:0]                   chg;
  logic [4:0]                   pulses;

  assign s_axis_tready_o = !m_valid_q || m_axis_tready_i;
  assign in_beat         = s_axis_tvalid_i && s_axis_tready_o;
  assign op              = rtc_pkg::op_e'(s_axis_tuser_i[1:0]);
  assign idx             = s_axis_tuser_i[5:2];
  assign wd              = s_axis_tdata_i;

  always_comb begin
    sec_d      = sec_q;
    min_d      = min_q;
    hour_d     = hour_q;
    day_d      = day_q;
    alm_sec_d  = alm_sec_q;
    alm_min_d  = alm_min_q;
    alm_hour_d = alm_hour_q;
    ld_sec_d   = ld_sec_q;
    ld_min_d   = ld_min_q;
    ld_hour_d  = ld_hour_q;
    ld_day_d   = ld_day_q;
    ctrl_d     = ctrl_q;
    status_d   = status_q;
    rdata      = '0;
    berr       = 1'b0;
    warn       = 1'b0;
    alarm_chk  = 1'b0;
    pulse_on   = 1'b0;
    chg        = '0;

    if (in_beat) begin
      case (op)
        rtc_pkg::OP_TICK: begin
          if (ctrl_q[rtc_pkg::CTRL_EN]) begin
            chg[0] = 1'b1;
            chg[1] = sec_q >= rtc_pkg::SEC_MAX;
            chg[2] = chg[1] && (min_q >= rtc_pkg::SEC_MAX);
            chg[3] = chg[2] && (hour_q >= rtc_pkg::HOUR_MAX);
            sec_d  = chg[1] ? 8'd0 : sec_q + 8'd1;
            if (chg[1]) begin
              min_d = chg[2] ? 8'd0 : min_q + 8'd1;
            end
            if (chg[2]) begin
              hour_d = chg[3] ? 8'd0 : hour_q + 8'd1;
            end
            if (chg[3]) begin
              day_d = day_q + 1'b1;
            end
            status_d  = status_q | {1'b0, chg & ctrl_q[4:1]};
            alarm_chk = 1'b1;
            pulse_on  = 1'b1;
          end
        end
        rtc_pkg::OP_READ: begin
          if (ctrl_q[rtc_pkg::CTRL_EN] &&
              (idx inside {[rtc_pkg::REG_SEC:rtc_pkg::REG_DAY], rtc_pkg::REG_TIME})) begin
            alarm_chk = 1'b1;
            pulse_on  = 1'b1;
          end
          case (idx)
            rtc_pkg::REG_SEC:      rdata = 32'(sec_q);
            rtc_pkg::REG_MIN:      rdata = 32'(min_q);
            rtc_pkg::REG_HRS:      rdata = 32'(hour_q);
            rtc_pkg::REG_DAY:      rdata = 32'(day_q);
            rtc_pkg::REG_ALM_SEC:  rdata = 32'(alm_sec_q);
            rtc_pkg::REG_ALM_MIN:  rdata = 32'(alm_min_q);
            rtc_pkg::REG_ALM_HOUR: rdata = 32'(alm_hour_q);
            rtc_pkg::REG_CTRL:     rdata = ctrl_q;
            rtc_pkg::REG_LD_SEC:   rdata = 32'(ld_sec_q);
            rtc_pkg::REG_LD_MIN:   rdata = 32'(ld_min_q);
            rtc_pkg::REG_LD_HOUR:  rdata = 32'(ld_hour_q);
            rtc_pkg::REG_LD_DAY:   rdata = 32'(ld_day_q);
            rtc_pkg::REG_STATUS:   rdata = 32'(status_q);
            rtc_pkg::REG_REVISION: rdata = rtc_pkg::REVISION;
            rtc_pkg::REG_TIME: begin
              rdata = (32'(day_q) << 17) | (32'(hour_q) << 12) |
                      (32'(min_q) << 6) | 32'(sec_q);
            end
            default: berr = 1'b1;
          endcase
        end
        rtc_pkg::OP_WRITE: begin
          case (idx)
            rtc_pkg::REG_ALM_SEC:  alm_sec_d  = wd[7:0];
            rtc_pkg::REG_ALM_MIN:  alm_min_d  = wd[7:0];
            rtc_pkg::REG_ALM_HOUR: alm_hour_d = wd[7:0];
            rtc_pkg::REG_LD_SEC:   ld_sec_d   = wd[7:0];
            rtc_pkg::REG_LD_MIN:   ld_min_d   = wd[7:0];
            rtc_pkg::REG_LD_HOUR:  ld_hour_d  = wd[7:0];
            rtc_pkg::REG_LD_DAY:   ld_day_d   = wd[15:0];
            rtc_pkg::REG_CTRL: begin
              ctrl_d = wd;
              if (wd[rtc_pkg::CTRL_EN] && wd[rtc_pkg::CTRL_LOAD]) begin
                sec_d  = ld_sec_q;
                min_d  = ld_min_q;
                hour_d = ld_hour_q;
                day_d  = ld_day_q[rtc_pkg::DAY_BITS-1:0];
                ctrl_d[rtc_pkg::CTRL_LOAD] = 1'b0;
              end
            end
            rtc_pkg::REG_STATUS: begin
              status_d = status_q & ~wd[4:0];
              pulse_on = 1'b1;
            end
            default: berr = 1'b1;
          endcase
          warn = (alm_sec_d > rtc_pkg::SEC_MAX) || (alm_min_d > rtc_pkg::SEC_MAX) ||
                 (alm_hour_d > rtc_pkg::HOUR_MAX) || (ld_sec_d > rtc_pkg::SEC_MAX) ||
                 (ld_min_d > rtc_pkg::SEC_MAX) || (ld_hour_d > rtc_pkg::HOUR_MAX);
        end
        default: ;
      endcase

      if (alarm_chk && ctrl_d[rtc_pkg::CTRL_IALM] && (sec_d == alm_sec_d) &&
          (min_d == alm_min_d) && (hour_d == alm_hour_d)) begin
        status_d[rtc_pkg::ST_ALM] = 1'b1;
      end
    end
  end

  assign pulses      = pulse_on ? (ctrl_d[5:1] & status_d) : 5'd0;
  assign alarm_level = status_d[rtc_pkg::ST_ALM] && ctrl_d[rtc_pkg::CTRL_IALM];
  assign m_valid_d   = in_beat || (m_valid_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_q      <= '0;
      min_q      <= '0;
      hour_q     <= '0;
      day_q      <= '0;
      alm_sec_q  <= '0;
      alm_min_q  <= '0;
      alm_hour_q <= '0;
      ld_sec_q   <= '0;
      ld_min_q   <= '0;
      ld_hour_q  <= '0;
      ld_day_q   <= '0;
      ctrl_q     <= '0;
      status_q   <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      sec_q      <= sec_d;
      min_q      <= min_d;
      hour_q     <= hour_d;
      day_q      <= day_d;
      alm_sec_q  <= alm_sec_d;
      alm_min_q  <= alm_min_d;
      alm_hour_q <= alm_hour_d;
      ld_sec_q   <= ld_sec_d;
      ld_min_q   <= ld_min_d;
      ld_hour_q  <= ld_hour_d;
      ld_day_q   <= ld_day_d;
      ctrl_q     <= ctrl_d;
      status_q   <= status_d;
      m_valid_q  <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      m_data_q <= rdata;
      m_user_q <= {warn, berr, pulses, alarm_level};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

endmodule

[hdl/rtc_checker.sv]
// Port-level checks for the real-time clock top, bound to it.
`timescale 1ns / 1ps

module rtc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid_i,
  input logic                           s_axis_tready_o,
  input logic [rtc_pkg::IN_USER_W-1:0]  s_axis_tuser_i,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [rtc_pkg::DATA_W-1:0]     m_axis_tdata_o,
  input logic [rtc_pkg::OUT_USER_W-1:0] m_axis_tuser_o
);

  logic in_beat;
  assign in_beat = s_axis_tvalid_i && s_axis_tready_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result beat changed");

  a_beat_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> m_axis_tvalid_o)
    else $error("input beat gave no result");

  a_berr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[6] |-> m_axis_tdata_o == '0)
    else $error("bus error with nonzero read data");

  a_warn_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && (s_axis_tuser_i[1:0] != rtc_pkg::OP_WRITE) |=> !m_axis_tuser_o[7])
    else $error("range warning on a non-write beat");

  a_tick_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && (s_axis_tuser_i[1:0] == rtc_pkg::OP_TICK) |=>
      m_axis_tdata_o == '0 && !m_axis_tuser_o[6])
    else $error("tick beat returned data or bus error");

endmodule

bind rtc_day_time_counter_with_alarm_top rtc_checker u_rtc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

[dv/rtc_day_time_counter_with_alarm_top_tb.sv]
// Testbench for the real-time clock: directed table, then random accesses checked by a predictor.
`timescale 1ns / 1ps

module rtc_day_time_counter_with_alarm_top_tb;

  localparam logic [1:0]  OP_NONE     = 2'd3;
  localparam logic [3:0]  REG_UNDEF   = 4'd15;
  localparam logic [31:0] CW_EN       = 32'd1 << rtc_pkg::CTRL_EN;
  localparam logic [31:0] CW_LOAD     = 32'd1 << rtc_pkg::CTRL_LOAD;
  localparam logic [31:0] CW_IRQ_ALL  = 32'h0000_003E;
  localparam int          SEGMENTS    = 8;
  localparam int          SEG_BEATS   = 220;
  localparam int          HOLD_CYCLES = 80;
  localparam int          QUIET_LIMIT = 1000;

  typedef struct packed {
    logic [31:0] read_data;
    logic        alarm_level;
    logic [4:0]  irq_pulses;
    logic        bus_error;
    logic        range_warning;
  } rtc_result_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  idx;
    logic [31:0] wd;
    logic        typed;
    rtc_result_t want;
  } access_row_t;

  typedef enum int {FLOW_FREE, FLOW_SRC_GAPS, FLOW_SINK_STALLS, FLOW_BOTH} flow_e;

  localparam access_row_t DIRECTED [26] = '{
    '{rtc_pkg::OP_READ,  rtc_pkg::REG_SEC,      32'd0,         1'b1,
      '{32'd0, 1'b0, 5'd0, 1'b0, 1'b0}},
    '{rtc_pkg::OP_READ,  rtc_pkg::REG_REVISION, 32'd0,         1'b1,
      '{rtc_pkg::REVISION, 1'b0, 5'd0, 1'b0, 1'b0}},
    '{rtc_pkg::OP_READ,  REG_UNDEF,             32'd0,         1'b1,
      '{32'd0, 1'b0, 5'd0, 1'b1, 1'b0}},
    '{rtc_pkg::OP_WRITE, rtc_pkg::REG_SEC,      32'hFFFF_FFFF, 1'b1,
      '{32'd0, 1'b0, 5'd0, 1'b1, 1'b0}},
    '{rtc_pkg::OP_WRITE, rtc_pkg::REG_ALM_SEC,  32'hFFFF_FFFF, 1'b1,
      '{32'd0, 1'b0, 5'd0, 1'b0, 1'b1}},
    '{rtc_pkg::OP_WRITE, rtc_pkg::REG_ALM_SEC,  32'd59,        1'b0, '0},
    '{rtc_pkg::OP_WRITE, rtc_pkg::REG_ALM_MIN,  32'd59,        1'b0, '0},
    '{rtc_pkg::OP_WRITE, rtc_pkg::REG_ALM_HOUR, 32'd23,        1'b0, '0},
    '{rtc_pkg::OP_WRITE, rtc_pkg::REG_LD_SEC,   32'd57,        1'b0, '0},
    '{rtc_pkg::OP_WRITE, rtc_pkg::REG_LD_MIN,   32'd59,        1'b0, '0},
    '{rtc_pkg::OP_WRITE, rtc_pkg::REG_LD_HOUR,  32'd23,        1'b0, '0},
    '{rtc_pkg::OP_WRITE, rtc_pkg::REG_LD_DAY,   32'hFFFF_FFFF, 1'b0, '0},
    '{rtc_pkg::OP_WRITE, rtc_pkg::REG_CTRL,     CW_EN | CW_LOAD | CW_IRQ_ALL, 1'b0, '0},
    '{rtc_pkg::OP_TICK,  rtc_pkg::REG_SEC,      32'd0,         1'b0, '0},
    '{rtc_pkg::OP_TICK,  rtc_pkg::REG_SEC,      32'd0,         1'b0, '0},
    '{rtc_pkg::OP_TICK,  rtc_pkg::REG_SEC,      32'd0,         1'b0, '0},
    '{rtc_pkg::OP_READ,  rtc_pkg::REG_TIME,     32'd0,         1'b0, '0},
    '{rtc_pkg::OP_WRITE, rtc_pkg::REG_STATUS,   32'hFFFF_FFFF, 1'b0, '0},
    '{rtc_pkg::OP_WRITE, rtc_pkg::REG_LD_SEC,   32'h0000_00FF, 1'b0, '0},
    '{rtc_pkg::OP_WRITE, rtc_pkg::REG_CTRL,     CW_EN | CW_LOAD, 1'b0, '0},
    '{rtc_pkg::OP_TICK,  rtc_pkg::REG_SEC,      32'd0,         1'b0, '0},
    '{rtc_pkg::OP_WRITE, rtc_pkg::REG_CTRL,     32'd0,         1'b0, '0},
    '{rtc_pkg::OP_TICK,  rtc_pkg::REG_SEC,      32'd0,         1'b0, '0},
    '{rtc_pkg::OP_WRITE, rtc_pkg::REG_TIME,     32'd0,         1'b0, '0},
    '{OP_NONE,           rtc_pkg::REG_STATUS,   32'hFFFF_FFFF, 1'b0, '0},
    '{rtc_pkg::OP_WRITE, rtc_pkg::REG_CTRL,     32'hFFFF_FFFF, 1'b0, '0}
  };

  logic                           clk_i   = 1'b0;
  logic                           rst_ni  = 1'b0;
  logic                           s_valid = 1'b0;
  logic [rtc_pkg::IN_USER_W-1:0]  s_user  = '0;
  logic [rtc_pkg::DATA_W-1:0]     s_data  = '0;
  logic                           m_ready = 1'b0;
  logic                           s_axis_tready_o;
  logic                           m_axis_tvalid_o;
  logic [rtc_pkg::DATA_W-1:0]     m_axis_tdata_o;
  logic [rtc_pkg::OUT_USER_W-1:0] m_axis_tuser_o;

  // predictor copy of the clock
  logic [7:0]                   rtc_sec, rtc_min, rtc_hour;
  logic [rtc_pkg::DAY_BITS-1:0] rtc_day;
  logic [7:0]                   rtc_alarm [3];
  logic [31:0]                  rtc_ctrl;
  logic [7:0]                   rtc_load [3];
  logic [15:0]                  rtc_load_day;
  logic [4:0]                   rtc_status;

  rtc_result_t pending_results [$];
  int          fail_count   = 0;
  flow_e       flow         = FLOW_FREE;
  bit          hold_request = 1'b0;

  rtc_day_time_counter_with_alarm_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [4:0] irq_status();
    return rtc_ctrl[5:1] & rtc_status;
  endfunction

  function automatic void alarm_compare();
    if (rtc_ctrl[rtc_pkg::CTRL_IALM] && rtc_sec == rtc_alarm[0] &&
        rtc_min == rtc_alarm[1] && rtc_hour == rtc_alarm[2])
      rtc_status[rtc_pkg::ST_ALM] = 1'b1;
  endfunction

  function automatic void advance_second();
    logic [3:0] changed;
    changed = 4'b0001;
    if (rtc_sec >= rtc_pkg::SEC_MAX) begin
      rtc_sec = '0;
      changed[1] = 1'b1;
      if (rtc_min >= rtc_pkg::SEC_MAX) begin
        rtc_min = '0;
        changed[2] = 1'b1;
        if (rtc_hour >= rtc_pkg::HOUR_MAX) begin
          rtc_hour = '0;
          changed[3] = 1'b1;
          rtc_day = rtc_day + 1'b1;
        end else begin
          rtc_hour = rtc_hour + 1'b1;
        end
      end else begin
        rtc_min = rtc_min + 1'b1;
      end
    end else begin
      rtc_sec = rtc_sec + 1'b1;
    end
    rtc_status[3:0] = rtc_status[3:0] | (changed & rtc_ctrl[4:1]);
    alarm_compare();
  endfunction

  function automatic logic range_exceeded();
    return rtc_alarm[0] > rtc_pkg::SEC_MAX || rtc_alarm[1] > rtc_pkg::SEC_MAX ||
           rtc_alarm[2] > rtc_pkg::HOUR_MAX || rtc_load[0] > rtc_pkg::SEC_MAX ||
           rtc_load[1] > rtc_pkg::SEC_MAX || rtc_load[2] > rtc_pkg::HOUR_MAX;
  endfunction

  function automatic rtc_result_t apply_bus_access(input logic [1:0] op, input logic [3:0] idx,
                                                   input logic [31:0] wd);
    rtc_result_t res;
    logic [31:0] word;
    logic [4:0]  irqs;
    res  = '0;
    word = wd;
    case (op)
      rtc_pkg::OP_TICK: begin
        if (rtc_ctrl[rtc_pkg::CTRL_EN]) begin
          advance_second();
          res.irq_pulses = irq_status();
        end
      end
      rtc_pkg::OP_READ: begin
        if ((idx <= rtc_pkg::REG_DAY || idx == rtc_pkg::REG_TIME) &&
            rtc_ctrl[rtc_pkg::CTRL_EN]) begin
          alarm_compare();
          res.irq_pulses = irq_status();
        end
        case (idx)
          rtc_pkg::REG_SEC:      res.read_data = 32'(rtc_sec);
          rtc_pkg::REG_MIN:      res.read_data = 32'(rtc_min);
          rtc_pkg::REG_HRS:      res.read_data = 32'(rtc_hour);
          rtc_pkg::REG_DAY:      res.read_data = 32'(rtc_day);
          rtc_pkg::REG_ALM_SEC, rtc_pkg::REG_ALM_MIN, rtc_pkg::REG_ALM_HOUR:
            res.read_data = 32'(rtc_alarm[2'(idx - rtc_pkg::REG_ALM_SEC)]);
          rtc_pkg::REG_CTRL:     res.read_data = rtc_ctrl;
          rtc_pkg::REG_LD_SEC, rtc_pkg::REG_LD_MIN, rtc_pkg::REG_LD_HOUR:
            res.read_data = 32'(rtc_load[2'(idx - rtc_pkg::REG_LD_SEC)]);
          rtc_pkg::REG_LD_DAY:   res.read_data = 32'(rtc_load_day);
          rtc_pkg::REG_STATUS:   res.read_data = 32'(rtc_status);
          rtc_pkg::REG_REVISION: res.read_data = rtc_pkg::REVISION;
          rtc_pkg::REG_TIME:
            res.read_data = (32'(rtc_day) << 17) | (32'(rtc_hour) << 12) |
                            (32'(rtc_min) << 6) | 32'(rtc_sec);
          default:               res.bus_error = 1'b1;
        endcase
      end
      rtc_pkg::OP_WRITE: begin
        case (idx)
          rtc_pkg::REG_ALM_SEC, rtc_pkg::REG_ALM_MIN, rtc_pkg::REG_ALM_HOUR:
            rtc_alarm[2'(idx - rtc_pkg::REG_ALM_SEC)] = wd[7:0];
          rtc_pkg::REG_LD_SEC, rtc_pkg::REG_LD_MIN, rtc_pkg::REG_LD_HOUR:
            rtc_load[2'(idx - rtc_pkg::REG_LD_SEC)] = wd[7:0];
          rtc_pkg::REG_LD_DAY: rtc_load_day = wd[15:0];
          rtc_pkg::REG_CTRL: begin
            if (word[rtc_pkg::CTRL_EN] && word[rtc_pkg::CTRL_LOAD]) begin
              rtc_sec  = rtc_load[0];
              rtc_min  = rtc_load[1];
              rtc_hour = rtc_load[2];
              rtc_day  = rtc_load_day[rtc_pkg::DAY_BITS-1:0];
              word[rtc_pkg::CTRL_LOAD] = 1'b0;
            end
            rtc_ctrl = word;
          end
          rtc_pkg::REG_STATUS: begin
            rtc_status = rtc_status & ~wd[4:0];
            res.irq_pulses = irq_status();
          end
          default: res.bus_error = 1'b1;
        endcase
        res.range_warning = range_exceeded();
      end
      default: ;
    endcase
    irqs = irq_status();
    res.alarm_level = irqs[rtc_pkg::ST_ALM];
    return res;
  endfunction

  function automatic bit source_idles();
    if (flow == FLOW_SRC_GAPS) return $urandom_range(0, 99) < 53;
    if (flow == FLOW_BOTH) return $urandom_range(0, 99) < 24;
    return 1'b0;
  endfunction

  function automatic bit sink_stalls();
    if (flow == FLOW_SINK_STALLS) return $urandom_range(0, 99) < 53;
    if (flow == FLOW_BOTH) return $urandom_range(0, 99) < 24;
    return 1'b0;
  endfunction

  task automatic send_access(input logic [1:0] op, input logic [3:0] idx, input logic [31:0] wd,
                             input logic typed, input rtc_result_t want);
    rtc_result_t predicted;
    while (source_idles()) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= {idx, op};
    s_data  <= wd;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predicted = apply_bus_access(op, idx, wd);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // mostly well-formed register traffic steered toward rollovers and alarm hits
  task automatic pick_random_access(output logic [1:0] op, output logic [3:0] idx,
                                    output logic [31:0] wd);
    int r;
    r   = $urandom_range(0, 99);
    idx = 4'($urandom_range(0, 15));
    wd  = $urandom;
    if (r < 2) begin
      op = OP_NONE;
    end else if (r < 52) begin
      op = rtc_pkg::OP_TICK;
    end else if (r < 74) begin
      op = rtc_pkg::OP_READ;
    end else begin
      op = rtc_pkg::OP_WRITE;
      r  = $urandom_range(0, 9);
      if (r < 3) begin
        idx = 4'($urandom_range(rtc_pkg::REG_ALM_SEC, rtc_pkg::REG_ALM_HOUR));
        if ($urandom_range(0, 4) != 0) begin
          case (idx)
            rtc_pkg::REG_ALM_SEC: wd = $urandom_range(0, rtc_pkg::SEC_MAX);
            rtc_pkg::REG_ALM_MIN: wd = 32'(rtc_min);
            default:              wd = 32'(rtc_hour);
          endcase
        end
      end else if (r < 5) begin
        idx = 4'($urandom_range(rtc_pkg::REG_LD_SEC, rtc_pkg::REG_LD_DAY));
        if ($urandom_range(0, 5) != 0) begin
          case (idx)
            rtc_pkg::REG_LD_SEC, rtc_pkg::REG_LD_MIN:
              wd = $urandom_range(50, rtc_pkg::SEC_MAX);
            rtc_pkg::REG_LD_HOUR:
              wd = $urandom_range(20, rtc_pkg::HOUR_MAX);
            default:
              wd = ($urandom_range(0, 3) == 0) ? 32'h0000_FFFF : $urandom_range(0, 65535);
          endcase
        end
      end else if (r < 7) begin
        idx = rtc_pkg::REG_CTRL;
        if ($urandom_range(0, 7) != 0) begin
          wd = ($urandom & CW_IRQ_ALL) | CW_EN;
          if ($urandom_range(0, 3) == 0) wd = wd | CW_LOAD;
        end
      end else if (r == 7) begin
        idx = rtc_pkg::REG_STATUS;
      end
    end
  endtask

  task automatic compare_result(input rtc_result_t want, input rtc_result_t got);
    if (got.read_data !== want.read_data) begin
      $error("read_data: expected %h, got %h", want.read_data, got.read_data);
      fail_count++;
    end
    if (got.alarm_level !== want.alarm_level) begin
      $error("alarm_level: expected %b, got %b", want.alarm_level, got.alarm_level);
      fail_count++;
    end
    if (got.irq_pulses !== want.irq_pulses) begin
      $error("irq_pulses: expected %b, got %b", want.irq_pulses, got.irq_pulses);
      fail_count++;
    end
    if (got.bus_error !== want.bus_error) begin
      $error("bus_error: expected %b, got %b", want.bus_error, got.bus_error);
      fail_count++;
    end
    if (got.range_warning !== want.range_warning) begin
      $error("range_warning: expected %b, got %b", want.range_warning, got.range_warning);
      fail_count++;
    end
  endtask

  initial begin : sink_side
    int k;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        m_ready <= 1'b0;
        for (k = 0; k < HOLD_CYCLES; k++) @(posedge clk_i);
        hold_request = 1'b0;
      end
      m_ready <= !sink_stalls();
    end
  end

  initial begin : result_checker
    rtc_result_t got;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid_o && m_ready) begin
        got.read_data     = m_axis_tdata_o;
        got.alarm_level   = m_axis_tuser_o[0];
        got.irq_pulses    = m_axis_tuser_o[5:1];
        got.bus_error     = m_axis_tuser_o[6];
        got.range_warning = m_axis_tuser_o[7];
        if (pending_results.size() == 0) begin
          $error("result beat with nothing outstanding");
          fail_count++;
        end else begin
          compare_result(pending_results.pop_front(), got);
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready)) quiet = 0;
      else quiet++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [1:0]  op;
    logic [3:0]  idx;
    logic [31:0] wd;
    rtc_sec = '0; rtc_min = '0; rtc_hour = '0; rtc_day = '0;
    rtc_alarm = '{default: '0};
    rtc_load  = '{default: '0};
    rtc_ctrl = '0; rtc_load_day = '0; rtc_status = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[i])
      send_access(DIRECTED[i].op, DIRECTED[i].idx, DIRECTED[i].wd, DIRECTED[i].typed,
                  DIRECTED[i].want);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      flow = flow_e'(seg % 4);
      if (seg == 4) hold_request = 1'b1;
      for (int n = 0; n < SEG_BEATS; n++) begin
        pick_random_access(op, idx, wd);
        send_access(op, idx, wd, 1'b0, '0);
      end
      s_valid <= 1'b0;
      do @(posedge clk_i); while (pending_results.size() != 0);
    end

    repeat (4) @(posedge clk_i);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
